### src/urod_pkg.sv
// ----------------------------------------------------------------------------
// urod_pkg
// Shared types, register codes and reset values for the ultrasonic ranger
// with obstacle-avoid motor drive.
// ----------------------------------------------------------------------------
package urod_pkg;

  localparam int ECHO_COUNT_BITS_DEF = 24;

  localparam int TRIG_W   = 16;
  localparam int SCALE_W  = 16;
  localparam int DIST_W   = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST  = 16'd11;
  localparam logic [SCALE_W-1:0] DISTANCE_SCALE_RST = 16'd1124;
  localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RST = 24'd2816;

  localparam logic [DIST_W-1:0]  DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [2:0] {
    PH_TRIGGER = 3'b001,
    PH_WAIT    = 3'b010,
    PH_COUNT   = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [SCALE_W-1:0] distance_scale;
    logic [DIST_W-1:0]  near_threshold;
  } cfg_t;

  typedef struct packed {
    logic              trigger_out;
    logic              left_forward;
    logic              left_reverse;
    logic              right_forward;
    logic              right_reverse;
    logic              distance_valid;
    logic [DIST_W-1:0] distance_out;
    logic              obstacle_near;
  } result_t;

endpackage

### src/urod_cfg_regs.sv
// ----------------------------------------------------------------------------
// urod_cfg_regs
// Configuration register file: trigger length, distance scale and near
// threshold, written through a plain index/data port.
// ----------------------------------------------------------------------------
module urod_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [urod_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urod_pkg::CFG_W-1:0]     cfg_data,
  output urod_pkg::cfg_t                cfg,
  output logic [urod_pkg::SCALE_W-1:0]  scale_nxt
);
  import urod_pkg::*;

  logic [TRIG_W-1:0]  trigger_ticks_r,  trigger_ticks_nxt;
  logic [SCALE_W-1:0] distance_scale_r, distance_scale_nxt;
  logic [DIST_W-1:0]  near_threshold_r, near_threshold_nxt;

  always_comb begin
    trigger_ticks_nxt  = trigger_ticks_r;
    distance_scale_nxt = distance_scale_r;
    near_threshold_nxt = near_threshold_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER_TICKS:  trigger_ticks_nxt  = cfg_data[TRIG_W-1:0];
        CFG_DISTANCE_SCALE: distance_scale_nxt = cfg_data[SCALE_W-1:0];
        CFG_NEAR_THRESHOLD: near_threshold_nxt = cfg_data[DIST_W-1:0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r  <= TRIGGER_TICKS_RST;
      distance_scale_r <= DISTANCE_SCALE_RST;
      near_threshold_r <= NEAR_THRESHOLD_RST;
    end else begin
      trigger_ticks_r  <= trigger_ticks_nxt;
      distance_scale_r <= distance_scale_nxt;
      near_threshold_r <= near_threshold_nxt;
    end
  end

  assign cfg.trigger_ticks  = trigger_ticks_r;
  assign cfg.distance_scale = distance_scale_r;
  assign cfg.near_threshold = near_threshold_r;
  assign scale_nxt          = distance_scale_nxt;

endmodule

### src/urod_ranger.sv
// ----------------------------------------------------------------------------
// urod_ranger
// Measurement state machine and motor direction state. Each step consumes
// one echo sample and yields one result. The scaled echo product is kept
// registered alongside the count so a completed echo needs only a shift,
// a saturate and a compare.
// ----------------------------------------------------------------------------
module urod_ranger #(
  parameter int ECHO_COUNT_BITS = urod_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         echo,
  input  urod_pkg::cfg_t               cfg,
  input  logic [urod_pkg::SCALE_W-1:0] scale_nxt,
  output urod_pkg::result_t            res
);
  import urod_pkg::*;

  localparam int PW = ECHO_COUNT_BITS + SCALE_W;   // product width
  localparam int DW = PW - 8;                      // product >> 8
  localparam int XW = (DW > DIST_W) ? DW : DIST_W;

  phase_t                     phase_r, phase_nxt;
  logic [TRIG_W-1:0]          trig_cnt_r, trig_cnt_nxt, trig_cnt_inc;
  logic [ECHO_COUNT_BITS-1:0] echo_cnt_r, echo_cnt_nxt, echo_cnt_sel;
  dir_t                       left_r, left_nxt, right_r, right_nxt;
  logic [DIST_W-1:0]          dist_r, dist_nxt, dist_calc;
  logic [PW-1:0]              prod_r;
  logic [XW-1:0]              dist_ext;
  logic                       trig, valid;

  // Distance from the registered product: shift, then saturate
  assign dist_ext  = XW'(prod_r[PW-1:8]);
  assign dist_calc = (dist_ext > XW'(DIST_MAX)) ? DIST_MAX : dist_ext[DIST_W-1:0];

  assign trig_cnt_inc = trig_cnt_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    trig_cnt_nxt = trig_cnt_r;
    echo_cnt_nxt = echo_cnt_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    dist_nxt     = dist_r;
    trig         = 1'b0;
    valid        = 1'b0;
    case (phase_r)
      PH_WAIT: begin
        if (echo) begin
          echo_cnt_nxt = ECHO_COUNT_BITS'(1);
          phase_nxt    = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (echo_cnt_r != {ECHO_COUNT_BITS{1'b1}}) begin
            echo_cnt_nxt = echo_cnt_r + 1'b1;
          end
        end else begin
          dist_nxt = dist_calc;
          if (dist_calc < cfg.near_threshold) begin
            left_nxt  = DIR_REV;
            right_nxt = DIR_FWD;
          end else begin
            left_nxt  = DIR_FWD;
            right_nxt = DIR_FWD;
          end
          valid        = 1'b1;
          echo_cnt_nxt = '0;
          trig_cnt_nxt = '0;
          phase_nxt    = PH_TRIGGER;
        end
      end
      default: begin
        // trigger phase, and any stray code
        trig = 1'b1;
        if (trig_cnt_inc >= cfg.trigger_ticks || trig_cnt_inc == '0) begin
          trig_cnt_nxt = '0;
          phase_nxt    = PH_WAIT;
        end else begin
          trig_cnt_nxt = trig_cnt_inc;
          phase_nxt    = PH_TRIGGER;
        end
      end
    endcase
  end

  // Keep prod_r == echo_cnt_r * distance_scale across steps and config writes
  assign echo_cnt_sel = step ? echo_cnt_nxt : echo_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TRIGGER;
      trig_cnt_r <= '0;
      echo_cnt_r <= '0;
      left_r     <= DIR_STOP;
      right_r    <= DIR_STOP;
      dist_r     <= '0;
      prod_r     <= '0;
    end else begin
      prod_r <= PW'(echo_cnt_sel) * PW'(scale_nxt);
      if (step) begin
        phase_r    <= phase_nxt;
        trig_cnt_r <= trig_cnt_nxt;
        echo_cnt_r <= echo_cnt_nxt;
        left_r     <= left_nxt;
        right_r    <= right_nxt;
        dist_r     <= dist_nxt;
      end
    end
  end

  assign res.trigger_out    = trig;
  assign res.left_forward   = (left_nxt == DIR_FWD);
  assign res.left_reverse   = (left_nxt == DIR_REV);
  assign res.right_forward  = (right_nxt == DIR_FWD);
  assign res.right_reverse  = (right_nxt == DIR_REV);
  assign res.distance_valid = valid;
  assign res.distance_out   = dist_nxt;
  assign res.obstacle_near  = (left_nxt == DIR_REV);

  a_prod_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    prod_r == PW'(echo_cnt_r) * PW'(cfg.distance_scale))
    else $error("scaled product out of step with echo count");

  a_count_only_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_COUNT |-> echo_cnt_r == '0)
    else $error("echo count nonzero outside count phase");

  a_trig_only_in_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    trig_cnt_r != '0 |-> phase_r == PH_TRIGGER)
    else $error("trigger count nonzero outside trigger phase");

  a_valid_ends_measure: assert property (@(posedge clk) disable iff (!rst_n)
    step && valid |=> phase_r == PH_TRIGGER && echo_cnt_r == '0)
    else $error("completed measurement did not restart trigger");

endmodule

### src/ultrasonic_ranger_obstacle_drive.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_obstacle_drive
// Echo ranger with obstacle-avoid drive: trigger pulse, echo timing, scaling
// to 1/256 cm and a spin / forward motor pattern, one echo sample per tick.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  --------------------------------
//  in_      input      in_valid / in_ready     in_echo_level
//  out_     output     out_valid / out_ready   trigger, motor pins, distance,
//                                              distance_valid, obstacle_near
//  cfg_     input      cfg_we (no wait)        cfg_index, cfg_data
//
//  One transaction per clock sustained while out_ready stays high; each
//  sample passes through the input register, then the result register,
//  where its result is held until the consumer takes it.
//  The per-sample work is one pass of compare/increment logic; the echo
//  count times scale product is held in a register beside the count.
//  in_ready falls only when both the input and result registers are full
//  and out_ready is low.
//  Reset (synchronous, rst_n low) loads the register defaults, enters the
//  trigger phase with motors stopped and empties both stages.
//
module ultrasonic_ranger_obstacle_drive #(
  parameter int ECHO_COUNT_BITS = urod_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // sample input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_echo_level,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_trigger_out,
  output logic                           out_left_forward,
  output logic                           out_left_reverse,
  output logic                           out_right_forward,
  output logic                           out_right_reverse,
  output logic                           out_distance_valid,
  output logic [urod_pkg::DIST_W-1:0]    out_distance_out,
  output logic                           out_obstacle_near,
  // configuration
  input  logic                           cfg_we,
  input  logic [urod_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urod_pkg::CFG_W-1:0]     cfg_data
);
  import urod_pkg::*;

  cfg_t                cfg;
  logic [SCALE_W-1:0]  scale_nxt;
  result_t             res;
  result_t             out_data_r;
  logic                in_vld_r, in_echo_r;
  logic                out_vld_r;
  logic                advance;

  urod_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .scale_nxt (scale_nxt)
  );

  // Advance the held sample into the result register when that slot frees.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  urod_ranger #(
    .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
  ) u_ranger (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .echo      (in_echo_r),
    .cfg       (cfg),
    .scale_nxt (scale_nxt),
    .res       (res)
  );

  // Input register: hold the sample until the state machine takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_echo_r <= in_echo_level;
    end
  end

  // Result register: load on advance, drop once the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_trigger_out    = out_data_r.trigger_out;
  assign out_left_forward   = out_data_r.left_forward;
  assign out_left_reverse   = out_data_r.left_reverse;
  assign out_right_forward  = out_data_r.right_forward;
  assign out_right_reverse  = out_data_r.right_reverse;
  assign out_distance_valid = out_data_r.distance_valid;
  assign out_distance_out   = out_data_r.distance_out;
  assign out_obstacle_near  = out_data_r.obstacle_near;

endmodule

### dv/urod_range_checker.sv
// ----------------------------------------------------------------------------
// urod_range_checker
// Watches the sample, result and register ports of the echo ranger, predicts
// every result from a model of its own and compares field by field.
// ----------------------------------------------------------------------------
module urod_range_checker #(
  parameter int ECHO_COUNT_BITS = urod_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_echo_level,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_trigger_out,
  input  logic                           out_left_forward,
  input  logic                           out_left_reverse,
  input  logic                           out_right_forward,
  input  logic                           out_right_reverse,
  input  logic                           out_distance_valid,
  input  logic [urod_pkg::DIST_W-1:0]    out_distance_out,
  input  logic                           out_obstacle_near,
  input  logic                           cfg_we,
  input  logic [urod_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urod_pkg::CFG_W-1:0]     cfg_data,
  output int                             mismatch_count,
  output int                             pending_results,
  output int                             result_count
);
  import urod_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                       ranger_cfg;
  phase_t                     ranger_phase;
  logic [TRIG_W-1:0]          trig_ticks_seen;
  logic [ECHO_COUNT_BITS-1:0] echo_ticks_seen;
  dir_t                       left_dir;
  dir_t                       right_dir;
  logic [DIST_W-1:0]          last_dist;

  result_t expected_drive[$];
  result_t want_res;

  function automatic logic [DIST_W-1:0] scaled_distance(
    input logic [ECHO_COUNT_BITS-1:0] ticks,
    input logic [SCALE_W-1:0]         scale
  );
    logic [ECHO_COUNT_BITS+SCALE_W-1:0] prod;
    prod = ticks * scale;
    prod = prod >> 8;
    if (prod > DIST_MAX) begin
      return DIST_MAX;
    end
    return prod[DIST_W-1:0];
  endfunction

  // Advance the ranger model by one echo sample and return the drive it shows.
  function automatic result_t predict_drive_step(input logic echo);
    result_t r;
    r = '0;
    case (ranger_phase)
      PH_WAIT: begin
        if (echo) begin
          echo_ticks_seen = ECHO_COUNT_BITS'(1);
          ranger_phase    = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (echo_ticks_seen != '1) echo_ticks_seen = echo_ticks_seen + 1'b1;
        end else begin
          last_dist = scaled_distance(echo_ticks_seen, ranger_cfg.distance_scale);
          if (last_dist < ranger_cfg.near_threshold) begin
            left_dir  = DIR_REV;
            right_dir = DIR_FWD;
          end else begin
            left_dir  = DIR_FWD;
            right_dir = DIR_FWD;
          end
          r.distance_valid = 1'b1;
          echo_ticks_seen  = '0;
          trig_ticks_seen  = '0;
          ranger_phase     = PH_TRIGGER;
        end
      end
      default: begin
        r.trigger_out   = 1'b1;
        trig_ticks_seen = trig_ticks_seen + 1'b1;
        if (trig_ticks_seen >= ranger_cfg.trigger_ticks || trig_ticks_seen == '0) begin
          trig_ticks_seen = '0;
          ranger_phase    = PH_WAIT;
        end
      end
    endcase
    r.left_forward  = (left_dir == DIR_FWD);
    r.left_reverse  = (left_dir == DIR_REV);
    r.right_forward = (right_dir == DIR_FWD);
    r.right_reverse = (right_dir == DIR_REV);
    r.distance_out  = last_dist;
    r.obstacle_near = (left_dir == DIR_REV);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                             input logic [DIST_W-1:0] seen);
    if (seen !== want) begin
      if (mismatch_count < 10) begin
        $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                 result_count, name, want, seen);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ranger_cfg.trigger_ticks  <= TRIGGER_TICKS_RST;
      ranger_cfg.distance_scale <= DISTANCE_SCALE_RST;
      ranger_cfg.near_threshold <= NEAR_THRESHOLD_RST;
      ranger_phase    = PH_TRIGGER;
      trig_ticks_seen = '0;
      echo_ticks_seen = '0;
      left_dir        = DIR_STOP;
      right_dir       = DIR_STOP;
      last_dist       = '0;
      expected_drive.delete();
      mismatch_count  = 0;
      result_count    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("MISMATCH result %0d arrived with nothing expected", result_count);
          end
          mismatch_count++;
        end else begin
          want_res = expected_drive.pop_front();
          check_field("trigger_out",    want_res.trigger_out,    out_trigger_out);
          check_field("left_forward",   want_res.left_forward,   out_left_forward);
          check_field("left_reverse",   want_res.left_reverse,   out_left_reverse);
          check_field("right_forward",  want_res.right_forward,  out_right_forward);
          check_field("right_reverse",  want_res.right_reverse,  out_right_reverse);
          check_field("distance_valid", want_res.distance_valid, out_distance_valid);
          check_field("distance_out",   want_res.distance_out,   out_distance_out);
          check_field("obstacle_near",  want_res.obstacle_near,  out_obstacle_near);
        end
        result_count++;
      end
      if (in_valid && in_ready) begin
        expected_drive.push_back(predict_drive_step(in_echo_level));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_TICKS:  ranger_cfg.trigger_ticks  <= cfg_data[TRIG_W-1:0];
          CFG_DISTANCE_SCALE: ranger_cfg.distance_scale <= cfg_data[SCALE_W-1:0];
          CFG_NEAR_THRESHOLD: ranger_cfg.near_threshold <= cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
    end
    pending_results = expected_drive.size();
  end

endmodule

### dv/tb_ultrasonic_ranger_obstacle_drive.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_ranger_obstacle_drive
// Drives echo samples and register settings into the ranger; a checker module
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_ultrasonic_ranger_obstacle_drive;
  import urod_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
  localparam int DRAIN_TAIL     = 8;     // settle cycles after the last result
  localparam int RANDOM_TARGET  = 72;    // samples per random phase

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_echo_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_trigger_out;
  logic                 out_left_forward;
  logic                 out_left_reverse;
  logic                 out_right_forward;
  logic                 out_right_reverse;
  logic                 out_distance_valid;
  logic [DIST_W-1:0]    out_distance_out;
  logic                 out_obstacle_near;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TRIGGER_TICKS;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int pending_results;
  int result_count;

  int idle_pct = 0;       // chance per cycle that the sender holds off
  int stall_pct = 0;      // chance per cycle that the receiver stalls
  int trig_len = TRIGGER_TICKS_RST;
  int echo_samples = 0;   // samples sent outside the trigger pulse
  int measurements = 0;
  int stall_cycles = 0;
  int sent_total = 0;     // every accepted sample

  ultrasonic_ranger_obstacle_drive u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_echo_level      (in_echo_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_trigger_out    (out_trigger_out),
    .out_left_forward   (out_left_forward),
    .out_left_reverse   (out_left_reverse),
    .out_right_forward  (out_right_forward),
    .out_right_reverse  (out_right_reverse),
    .out_distance_valid (out_distance_valid),
    .out_distance_out   (out_distance_out),
    .out_obstacle_near  (out_obstacle_near),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  urod_range_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_echo_level      (in_echo_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_trigger_out    (out_trigger_out),
    .out_left_forward   (out_left_forward),
    .out_left_reverse   (out_left_reverse),
    .out_right_forward  (out_right_forward),
    .out_right_reverse  (out_right_reverse),
    .out_distance_valid (out_distance_valid),
    .out_distance_out   (out_distance_out),
    .out_obstacle_near  (out_obstacle_near),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .pending_results    (pending_results),
    .result_count       (result_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: decide readiness on each falling edge from the current stall mix.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one echo sample and hold it until the transaction completes.
  // Enter and leave on a falling edge; valid stays high on return so that
  // back-to-back samples never drop it.
  task automatic send_echo(input logic level);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_echo_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  // Write all three registers on consecutive cycles, only with the block idle.
  task automatic set_config(input logic [TRIG_W-1:0] trig, input logic [SCALE_W-1:0] scale,
                            input logic [DIST_W-1:0] thresh);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRIGGER_TICKS;
    cfg_data  <= CFG_W'(trig);
    @(negedge clk);
    cfg_index <= CFG_DISTANCE_SCALE;
    cfg_data  <= CFG_W'(scale);
    @(negedge clk);
    cfg_index <= CFG_NEAR_THRESHOLD;
    cfg_data  <= CFG_W'(thresh);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    // A zero length still gives a one-tick pulse.
    trig_len = (trig == '0) ? 1 : int'(trig);
  endtask

  // Trigger pulse: the echo pin is ignored here, so feed it random levels.
  task automatic run_trigger();
    repeat (trig_len) send_echo($urandom_range(1));
  endtask

  // One well-formed measurement from the wait phase: low ticks, a high echo,
  // the falling tick, then the next trigger pulse, ending back in wait.
  task automatic measure(input int low_ticks, input int high_ticks);
    repeat (low_ticks) send_echo(1'b0);
    repeat (high_ticks) send_echo(1'b1);
    send_echo(1'b0);
    echo_samples += low_ticks + high_ticks + 1;
    measurements++;
    run_trigger();
  endtask

  // Random levels in any phase, then enough low ticks to land in wait again:
  // one to end a count, then a full trigger pulse.
  task automatic noise_burst(input int len);
    repeat (len) send_echo($urandom_range(1));
    repeat (trig_len + 1) send_echo(1'b0);
    echo_samples += len;
  endtask

  // Pick a setting; keep the threshold near typical distances most of the time
  // so that both drive patterns show up.
  task automatic random_config();
    logic [TRIG_W-1:0]  trig;
    logic [SCALE_W-1:0] scale;
    logic [DIST_W-1:0]  thresh;
    int                 typical;
    trig  = ($urandom_range(99) < 10) ? '0 : TRIG_W'($urandom_range(1, 6));
    scale = ($urandom_range(99) < 15) ? SCALE_W'($urandom_range(0, 65535))
                                      : SCALE_W'($urandom_range(200, 3000));
    typical = (12 * int'(scale)) >> 8;
    thresh = ($urandom_range(99) < 15) ? DIST_W'($urandom_range(0, 24'hFF_FFFF))
                                       : DIST_W'($urandom_range(0, 2 * typical + 1));
    set_config(trig, scale, thresh);
  endtask

  task automatic random_phase(input int sender_idle, input int receiver_stall);
    int pick;
    int start;
    bit mid_done;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    start     = sent_total;
    mid_done  = 1'b0;
    random_config();
    while (sent_total - start < RANDOM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        noise_burst($urandom_range(1, 12));
      end else if (pick < 20) begin
        measure($urandom_range(0, 4), $urandom_range(30, 80));
      end else begin
        measure($urandom_range(0, 4), $urandom_range(1, 24));
      end
      // Halfway: hold off until the pipe is empty, then move to a new setting.
      if (!mid_done && sent_total - start >= RANDOM_TARGET / 2) begin
        drain();
        random_config();
        mid_done = 1'b1;
      end
    end
  endtask

  initial begin
    // Hold reset from time zero, then release it on a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, no idling, reset register values first.
    run_trigger();
    measure(0, 1);      // echo rises at once, shortest pulse: spin
    measure(2, 2);      // short echo after a few low ticks: spin
    noise_burst(6);

    set_config('0, DISTANCE_SCALE_RST, NEAR_THRESHOLD_RST);  // zero-length trigger
    measure(1, 3);
    // Full scale around the default 11 cm threshold: 11 ticks fall just
    // below it, 12 ticks just above it.
    set_config(TRIG_W'(1), {SCALE_W{1'b1}}, NEAR_THRESHOLD_RST);
    measure(0, 11);
    measure(0, 12);
    set_config(TRIG_W'(1), '0, NEAR_THRESHOLD_RST);           // zero scale: distance 0
    measure(0, 5);
    set_config(TRIG_W'(1), '0, '0);                           // 0 is not below 0
    measure(0, 5);
    // Largest threshold: any short echo is below it.
    set_config(TRIG_W'(2), DISTANCE_SCALE_RST, DIST_MAX);
    measure(0, 20);

    // Random part across the idle and stall mixes.
    random_phase(0, 0);
    random_phase(80, 0);
    random_phase(0, 80);
    random_phase(17, 17);

    idle_pct = 0;
    drain();

    $display("Summary: %0d samples, %0d echo samples in %0d measurements, %0d results checked",
             sent_total, echo_samples, measurements, result_count);
    $display("Summary: trigger 0/1/2, scale 0/max, threshold 0/max, near/far edge, four idle mixes");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_count, pending_results);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
